### rtl/sal_pkg.sv
// sal_pkg: shared types and constants of the sorted insertion list
// holds the word structs, operation and status codes, control states
// no dependencies
`default_nettype none

package sal_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int DATA_W       = 32;
    localparam int INDEX_W      = 7;
    localparam int COUNT_W      = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE  = 2'd0,
        FSM_EVAL  = 2'd1,
        FSM_APPLY = 2'd2
    } fsm_t;

    typedef struct packed {
        op_t                       op;
        logic signed [DATA_W-1:0]  value;
        logic [INDEX_W-1:0]        index;
    } in_word_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0]        count;
    } out_word_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic eval;
        logic ins;
        logic rem;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/sal_cell.sv
// sal_cell: one slot of the sorted list, compares and shifts with neighbors
// depends on sal_pkg
`default_nettype none

module sal_cell (
    input  wire                                 aclk,
    input  wire sal_pkg::cell_ctrl_t            ctrl,
    input  wire                                 active,
    input  wire                                 rd_sel,
    input  wire logic signed [sal_pkg::DATA_W-1:0] operand,
    input  wire logic signed [sal_pkg::DATA_W-1:0] left_entry,
    input  wire                                 left_lt,
    input  wire logic signed [sal_pkg::DATA_W-1:0] right_entry,
    output logic signed [sal_pkg::DATA_W-1:0]   entry,
    output logic                                lt,
    output logic                                hit,
    output logic [sal_pkg::DATA_W-1:0]          rd_word
);
    import sal_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic                     lt_reg;
    logic                     eq_reg;
    logic                     sel_reg;

    // compare flags, captured in the evaluate cycle
    always_ff @(posedge aclk) begin
        if (ctrl.eval) begin
            lt_reg  <= active && (entry_reg < operand);
            eq_reg  <= active && (entry_reg == operand);
            sel_reg <= rd_sel;
        end
    end

    // insert: first not-smaller slot takes the operand, later slots shift up
    // remove: slots from the match on take the right neighbor
    always_ff @(posedge aclk) begin
        if (ctrl.ins && !lt_reg) begin
            entry_reg <= left_lt ? operand : left_entry;
        end else if (ctrl.rem && !lt_reg) begin
            entry_reg <= right_entry;
        end
    end

    assign entry   = entry_reg;
    assign lt      = lt_reg;
    assign hit     = eq_reg && !lt_reg && left_lt;
    assign rd_word = sel_reg ? entry_reg : '0;

endmodule

`default_nettype wire

### rtl/sorted_array_list.sv
// sorted_array_list: top level, operand/result registers, control fsm and cell row
// depends on sal_pkg and sal_cell
//
//  channel | ports                     | payload
//  --------+---------------------------+-------------------------------
//  input   | s_valid s_ready s_data    | op, value, index
//  result  | m_valid m_ready m_data    | status, read_value, count
//
// each word passes through accept, evaluate (every cell compares its
// entry with the operand) and apply (all cells shift at once, result registered)
// a new word is taken once the previous result has left or leaves that cycle
// reset clears the count, fsm state and result valid only; stored entries need none
// a stalled result simply holds the input side off
`default_nettype none

module sorted_array_list #(
    parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire sal_pkg::in_word_t s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output sal_pkg::out_word_t    m_data
);
    import sal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > INDEX_W) ? CW : INDEX_W;

    fsm_t                     state_reg, state_next;
    op_t                      op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [INDEX_W-1:0]       idx_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic                     m_valid_reg;
    out_word_t                out_reg, out_next;
    cell_ctrl_t               ctrl;
    logic                     accept;
    logic                     full;
    logic                     found;
    logic [DATA_W-1:0]        rd_any;
    logic                     idx_ok;

    logic signed [DATA_W-1:0] entry_w [CAPACITY];
    logic [CAPACITY-1:0]      lt_w;
    logic [CAPACITY-1:0]      hit_w;
    logic [DATA_W-1:0]        rd_w [CAPACITY];

    assign accept = s_valid && s_ready;
    assign full   = (count_reg >= CW'(CAPACITY));
    assign idx_ok = (WW'(idx_reg) < WW'(count_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:  if (accept) state_next = FSM_EVAL;
            FSM_EVAL:  state_next = FSM_APPLY;
            FSM_APPLY: state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready  = 1'b0;
        ctrl     = '0;
        case (state_reg)
            FSM_IDLE:  s_ready = !m_valid_reg || m_ready;
            FSM_EVAL:  ctrl.eval = 1'b1;
            FSM_APPLY: begin
                ctrl.ins = (op_reg == OP_INSERT) && !full;
                ctrl.rem = (op_reg == OP_REMOVE) && found;
            end
            default:   s_ready = 1'b0;
        endcase
    end

    // the row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_e;
        logic signed [DATA_W-1:0] right_e;
        logic                     left_l;
        if (i == 0) begin : g_first
            assign left_e = val_reg;
            assign left_l = 1'b1;
        end else begin : g_mid
            assign left_e = entry_w[i-1];
            assign left_l = lt_w[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_e = entry_w[i];
        end else begin : g_inner
            assign right_e = entry_w[i+1];
        end

        sal_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .active      (WW'(i) < WW'(count_reg)),
            .rd_sel      (WW'(idx_reg) == WW'(i)),
            .operand     (val_reg),
            .left_entry  (left_e),
            .left_lt     (left_l),
            .right_entry (right_e),
            .entry       (entry_w[i]),
            .lt          (lt_w[i]),
            .hit         (hit_w[i]),
            .rd_word     (rd_w[i])
        );
    end

    // match flag and read word gathered across the row
    always_comb begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_any = rd_any | rd_w[i];
        end
    end
    assign found = |hit_w;

    // count update and result word
    always_comb begin
        count_next          = count_reg;
        out_next.status     = ST_DONE;
        out_next.read_value = '0;
        case (op_reg)
            OP_INSERT: begin
                if (full) out_next.status = ST_FULL;
                else      count_next = count_reg + CW'(1);
            end
            OP_REMOVE: begin
                if (found) count_next = count_reg - CW'(1);
                else       out_next.status = ST_NOT_FOUND;
            end
            OP_READ: begin
                if (idx_ok) out_next.read_value = rd_any;
                else        out_next.status = ST_RANGE;
            end
            default: out_next.status = ST_DONE;
        endcase
        out_next.count = COUNT_W'(count_next);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == FSM_APPLY) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // operand and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_data.op;
            val_reg <= s_data.value;
            idx_reg <= s_data.index;
        end
        if (state_reg == FSM_APPLY) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

### tb/sorted_array_list_tb.sv
`timescale 1ns / 1ps
// sorted_array_list_tb: self-checking bench for the sorted insertion list
// drives random and directed words, predicts each result, compares field by field
// depends on sal_pkg and the sorted_array_list rtl
module sorted_array_list_tb;
    import sal_pkg::*;

    localparam int LIST_CAP       = CAPACITY_DEF;
    localparam int ITEM_GOAL      = 1850;
    localparam int QUIET_LIMIT    = 2000;
    localparam int CALM_TAIL      = 150;
    localparam int SETTLE_CYCLES  = 12;

    typedef struct packed {
        logic [LIST_CAP-1:0][DATA_W-1:0] slot;
        logic [COUNT_W-1:0]              fill;
    } list_state_t;

    typedef struct packed {
        logic     drain_first;
        in_word_t word;
    } pending_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    pending_t    word_backlog[$];
    out_word_t   due_results[$];
    list_state_t plan_list = '0;
    list_state_t live_list = '0;

    int   total_items     = 0;
    int   words_sent      = 0;
    int   results_checked = 0;
    int   errors          = 0;
    int   peak_fill       = 0;
    int   status_seen[4]  = '{0, 0, 0, 0};
    int   send_gap        = 0;
    int   stall_left      = 0;
    int   quiet_cycles    = 0;
    logic drained         = 1'b1;

    sorted_array_list #(.CAPACITY(LIST_CAP)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // one list operation: updates the list and returns the result word
    function automatic out_word_t sorted_list_update(inout list_state_t st, input in_word_t w);
        out_word_t r;
        int        pos;
        int        j;
        r.status     = ST_DONE;
        r.read_value = '0;
        pos = 0;
        while (pos < st.fill && $signed(st.slot[pos]) < w.value) pos++;
        case (w.op)
            OP_INSERT: begin
                if (st.fill >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (j = int'(st.fill); j > pos; j--) st.slot[j] = st.slot[j-1];
                    st.slot[pos] = w.value;
                    st.fill = st.fill + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (pos < st.fill && st.slot[pos] == w.value) begin
                    for (j = pos; j + 1 < st.fill; j++) st.slot[j] = st.slot[j+1];
                    st.fill = st.fill - 1'b1;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_READ: begin
                if (w.index < st.fill) r.read_value = st.slot[w.index];
                else r.status = ST_RANGE;
            end
            default: ;
        endcase
        r.count = st.fill;
        return r;
    endfunction

    // idle rate in percent, by progress; the tail of the run has none
    function automatic int idle_pct(input int n);
        if (n >= total_items - CALM_TAIL) return 0;
        case ((n / 180) % 3)
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on result %0d, %s: got %0h, expected %0h",
                 $realtime, results_checked, what, got, want);
        errors++;
    endtask

    // ---------------- stimulus helpers ----------------

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = $urandom_range(0, 16);
            return v - 8;
        end
        if (r < 60) begin
            case ($urandom_range(0, 5))
                0:       return 32'sh8000_0000;
                1:       return 32'sh8000_0001;
                2:       return 32'sh7fff_ffff;
                3:       return 32'sh7fff_fffe;
                4:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [INDEX_W-1:0] stored_index();
        if (plan_list.fill == 0) return any_index();
        return INDEX_W'($urandom_range(0, plan_list.fill - 1));
    endfunction

    function automatic logic signed [DATA_W-1:0] stored_value();
        if (plan_list.fill == 0) return pick_value();
        return plan_list.slot[stored_index()];
    endfunction

    task automatic queue_word(input op_t op, input logic signed [DATA_W-1:0] value,
                              input logic [INDEX_W-1:0] index, input logic drain_first);
        pending_t  p;
        out_word_t ignored;
        p.drain_first = drain_first;
        p.word.op     = op;
        p.word.value  = value;
        p.word.index  = index;
        ignored = sorted_list_update(plan_list, p.word);
        word_backlog.push_back(p);
    endtask

    // grow the list toward target, poke it when full, shrink to floor, poke it if empty
    task automatic queue_round(input int target, input int floor_fill);
        int r;
        queue_word(OP_READ, $urandom, any_index(), 1'b1);
        while (plan_list.fill < target) begin
            r = $urandom_range(0, 99);
            if (r < 60)      queue_word(OP_INSERT, pick_value(), any_index(), 1'b0);
            else if (r < 66) queue_word(OP_INSERT, stored_value(), any_index(), 1'b0);
            else if (r < 78) queue_word(OP_READ, $urandom, stored_index(), 1'b0);
            else if (r < 84) queue_word(OP_READ, $urandom, any_index(), 1'b0);
            else if (r < 92) queue_word(OP_REMOVE, stored_value(), any_index(), 1'b0);
            else if (r < 97) queue_word(OP_REMOVE, pick_value(), any_index(), 1'b0);
            else             queue_word(OP_NONE, $urandom, any_index(), 1'b0);
        end
        if (plan_list.fill == LIST_CAP) begin
            repeat (3) queue_word(OP_INSERT, pick_value(), any_index(), 1'b0);
            queue_word(OP_READ, $urandom, 7'd127, 1'b0);
            queue_word(OP_READ, $urandom, 7'd0, 1'b0);
            queue_word(OP_REMOVE, stored_value(), any_index(), 1'b0);
            queue_word(OP_INSERT, stored_value(), any_index(), 1'b0);
        end
        while (plan_list.fill > floor_fill) begin
            r = $urandom_range(0, 99);
            if (r < 62)      queue_word(OP_REMOVE, stored_value(), any_index(), 1'b0);
            else if (r < 70) queue_word(OP_REMOVE, pick_value(), any_index(), 1'b0);
            else if (r < 85) queue_word(OP_READ, $urandom, stored_index(), 1'b0);
            else if (r < 90) queue_word(OP_READ, $urandom, any_index(), 1'b0);
            else if (r < 95) queue_word(OP_INSERT, pick_value(), any_index(), 1'b0);
            else             queue_word(OP_NONE, $urandom, any_index(), 1'b0);
        end
        if (plan_list.fill == 0) begin
            queue_word(OP_REMOVE, pick_value(), any_index(), 1'b0);
            queue_word(OP_READ, $urandom, 7'd0, 1'b0);
        end
    endtask

    // ---------------- stimulus and end of run ----------------

    initial begin
        int rounds;
        int target;
        // empty list, unused op, extremes, equal values, range edges
        queue_word(OP_READ, 32'sh0, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh0, 7'd0, 1'b0);
        queue_word(OP_NONE, -32'sd1, 7'd127, 1'b0);
        queue_word(OP_INSERT, 32'sh0, 7'd127, 1'b0);
        queue_word(OP_INSERT, 32'sh7fff_ffff, 7'd0, 1'b0);
        queue_word(OP_INSERT, 32'sh8000_0000, 7'd0, 1'b0);
        queue_word(OP_INSERT, -32'sd1, 7'd0, 1'b0);
        queue_word(OP_INSERT, 32'sh1, 7'd0, 1'b0);
        queue_word(OP_INSERT, 32'sh0, 7'd0, 1'b0);
        queue_word(OP_INSERT, 32'sh8000_0000, 7'd0, 1'b0);
        queue_word(OP_READ, 32'sh0, 7'd0, 1'b0);
        queue_word(OP_READ, -32'sd1, 7'd6, 1'b0);
        queue_word(OP_READ, 32'sh0, 7'd7, 1'b0);
        queue_word(OP_READ, 32'sh0, 7'd127, 1'b0);
        queue_word(OP_REMOVE, 32'sh5, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh7fff_fffe, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh7fff_ffff, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh8000_0000, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh0, 7'd0, 1'b0);
        queue_word(OP_READ, 32'sh0, 7'd2, 1'b0);
        queue_word(OP_NONE, 32'sh0, 7'd0, 1'b0);
        queue_word(OP_REMOVE, -32'sd1, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh1, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh0, 7'd0, 1'b0);
        queue_word(OP_REMOVE, 32'sh8000_0000, 7'd0, 1'b0);

        // fill/drain rounds, every other one to full capacity
        rounds = 0;
        while (word_backlog.size() < ITEM_GOAL) begin
            if (rounds % 2 == 0) target = LIST_CAP;
            else target = $urandom_range(2, LIST_CAP - 1);
            queue_round(target, (rounds % 3 == 0) ? 0 : $urandom_range(0, target / 2));
            rounds++;
        end
        total_items = word_backlog.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for every word to go in and every result to come back
        while (word_backlog.size() != 0 || s_valid || !drained) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("ran %0d words, checked %0d results, peak fill %0d of %0d",
                 words_sent, results_checked, peak_fill, LIST_CAP);
        $display("refused while full %0d, remove misses %0d, reads out of range %0d",
                 status_seen[ST_FULL], status_seen[ST_NOT_FOUND], status_seen[ST_RANGE]);
        if (errors == 0) begin
            $display("sorted_array_list verification clean");
        end else begin
            $display("sorted_array_list verification failed");
        end
        $finish;
    end

    // ---------------- driver ----------------

    // input side: next word from the backlog, random gaps, drain pauses
    always @(posedge aclk) begin : word_driver
        pending_t head;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (word_backlog.size() != 0 &&
                         (!word_backlog[0].drain_first || (!s_valid && drained))) begin
                head = word_backlog.pop_front();
                s_data  <= head.word;
                s_valid <= 1'b1;
                if ($urandom_range(0, 99) < idle_pct(words_sent))
                    send_gap <= $urandom_range(1, 12);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random stall bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 399) < idle_pct(results_checked)) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ---------------- monitor ----------------

    // check results against the oldest expectation, then predict accepted words
    always @(posedge aclk) begin : result_monitor
        out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result word", m_data.read_value, 32'd0);
                end else begin
                    want = due_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.read_value !== want.read_value)
                        report_mismatch("read_value", m_data.read_value, want.read_value);
                    if (m_data.count !== want.count)
                        report_mismatch("count", 32'(m_data.count), 32'(want.count));
                    status_seen[want.status]++;
                end
                results_checked <= results_checked + 1;
            end
            if (s_valid && s_ready) begin
                due_results.push_back(sorted_list_update(live_list, s_data));
                if (live_list.fill > peak_fill) peak_fill = int'(live_list.fill);
                words_sent <= words_sent + 1;
            end
            drained <= (due_results.size() == 0);
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results still due",
                     quiet_cycles, due_results.size());
            $display("sorted_array_list verification failed");
            $finish;
        end
    end

endmodule

### filelist.f
rtl/sal_pkg.sv
rtl/sal_cell.sv
rtl/sorted_array_list.sv
tb/sorted_array_list_tb.sv
